@@ hw/rtl/stream_substring_replace_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the stream substring replace unit
// Concurrent-assertion shorthands for the checker file ssr_checker.sv.
// ----------------------------------------------------------------------------
`ifndef STREAM_SUBSTRING_REPLACE_UNIT_MACROS_SVH
`define STREAM_SUBSTRING_REPLACE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ssr check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ssr check failed");

`endif

@@ hw/rtl/ssr_pkg.sv @@
// ----------------------------------------------------------------------------
// ssr_pkg
// Types and constants shared by the stream substring replace unit.
// ----------------------------------------------------------------------------
package ssr_pkg;

	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 4;   // length registers and burst counts
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SEARCH_PATTERN     = 4'd0,
		CFG_PATTERN_LENGTH     = 4'd1,
		CFG_REPLACEMENT_TEXT   = 4'd2,
		CFG_REPLACEMENT_LENGTH = 4'd3
	} cfg_reg_t;

	// control half of a result burst handed from the window to the output stage
	typedef struct packed {
		logic [LEN_W-1:0] count;
		logic             last;
	} burst_ctl_t;

endpackage

@@ hw/rtl/ssr_if.sv @@
// ----------------------------------------------------------------------------
// ssr interfaces
// Valid/ready channels for text input, rewritten output and configuration.
// ----------------------------------------------------------------------------
interface ssr_text_if;
	logic                       valid;
	logic                       ready;
	logic [ssr_pkg::BYTE_W-1:0] text_byte;
	logic                       text_last;

	modport source (output valid, output text_byte, output text_last, input ready);
	modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

interface ssr_out_if;
	logic                       valid;
	logic                       ready;
	logic [ssr_pkg::BYTE_W-1:0] out_byte;
	logic                       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

interface ssr_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ssr_pkg::CFG_IDX_W-1:0]  index;
	logic [ssr_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/ssr_window.sv @@
// ----------------------------------------------------------------------------
// ssr_window
// Pending-byte window, pattern compare and burst formation for one item.
// ----------------------------------------------------------------------------
module ssr_window #(
	parameter int MAX_PATTERN_BYTES     = 8,
	parameter int MAX_REPLACEMENT_BYTES = 8,
	parameter int BURST_DEPTH           = 8
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     commit,
	input  logic [ssr_pkg::BYTE_W-1:0]               text_byte,
	input  logic                                     text_last,
	input  logic [MAX_PATTERN_BYTES*ssr_pkg::BYTE_W-1:0]     pattern,
	input  logic [ssr_pkg::LEN_W-1:0]                plen,
	input  logic [MAX_REPLACEMENT_BYTES*ssr_pkg::BYTE_W-1:0] repl,
	input  logic [ssr_pkg::LEN_W-1:0]                rlen,
	output logic [ssr_pkg::BYTE_W-1:0]               burst_bytes [BURST_DEPTH],
	output ssr_pkg::burst_ctl_t                      burst_ctl
);

	localparam int FillW = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int LenW  = ssr_pkg::LEN_W;

	logic [ssr_pkg::BYTE_W-1:0] win_q [MAX_PATTERN_BYTES];
	logic [ssr_pkg::BYTE_W-1:0] wins  [MAX_PATTERN_BYTES];
	logic [ssr_pkg::BYTE_W-1:0] win_d [MAX_PATTERN_BYTES];
	logic [FillW-1:0]           fill_q;
	logic [FillW-1:0]           fill_d;
	logic [LenW-1:0]            fill1;
	logic [LenW-1:0]            pop;
	logic                       pass;
	logic                       all_eq;
	logic                       hit;

	// window with the new byte written at the fill point
	always_comb begin
		for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
			wins[i] = (fill_q == FillW'(i)) ? text_byte : win_q[i];
		end
	end

	always_comb begin
		all_eq = 1'b1;
		for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
			if (LenW'(i) < plen && wins[i] != pattern[ssr_pkg::BYTE_W*i +: ssr_pkg::BYTE_W])
				all_eq = 1'b0;
		end
	end

	assign fill1 = LenW'(fill_q) + LenW'(1);
	assign pass  = (plen == '0) || (rlen == '0);
	assign hit   = (fill1 == plen) && all_eq;
	assign pop   = fill1 - plen + LenW'(1);

	always_comb begin
		for (int i = 0; i < BURST_DEPTH; i++) begin
			burst_bytes[i] = '0;
		end
		for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
			burst_bytes[i] = wins[i];
			win_d[i]       = wins[i];
		end
		burst_ctl.last  = text_last;
		burst_ctl.count = '0;
		fill_d          = FillW'(fill1);

		if (pass) begin
			// either length zero: byte goes straight through, window dropped
			burst_bytes[0]  = text_byte;
			burst_ctl.count = LenW'(1);
			fill_d          = '0;
		end else if (hit) begin
			for (int i = 0; i < MAX_REPLACEMENT_BYTES; i++) begin
				burst_bytes[i] = repl[ssr_pkg::BYTE_W*i +: ssr_pkg::BYTE_W];
			end
			burst_ctl.count = rlen;
			fill_d          = '0;
		end else if (text_last) begin
			burst_ctl.count = fill1;
			fill_d          = '0;
		end else if (fill1 >= plen) begin
			// emit oldest bytes until the window is one short of the pattern
			burst_ctl.count = pop;
			fill_d          = FillW'(plen - LenW'(1));
			for (int k = 1; k <= MAX_PATTERN_BYTES; k++) begin
				for (int i = 0; i < MAX_PATTERN_BYTES - k; i++) begin
					if (pop == LenW'(k))
						win_d[i] = wins[i + k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			win_q <= win_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (commit) begin
			fill_q <= fill_d;
		end
	end

endmodule

@@ hw/rtl/ssr_burst.sv @@
// ----------------------------------------------------------------------------
// ssr_burst
// Result register holds one item's burst, sent a byte a cycle unless stalled.
// ----------------------------------------------------------------------------
module ssr_burst #(
	parameter int BURST_DEPTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic [ssr_pkg::BYTE_W-1:0] burst_bytes [BURST_DEPTH],
	input  ssr_pkg::burst_ctl_t        burst_ctl,
	output logic                       free,
	ssr_out_if.source                  text_out
);

	localparam int IdxW = (BURST_DEPTH > 1) ? $clog2(BURST_DEPTH) : 1;
	localparam int LenW = ssr_pkg::LEN_W;

	logic [ssr_pkg::BYTE_W-1:0] data_s2 [BURST_DEPTH];
	logic [LenW-1:0]            rem_s2;
	logic [IdxW-1:0]            idx_s2;
	logic                       last_s2;
	logic                       fire;

	assign fire              = text_out.valid && text_out.ready;
	assign text_out.valid    = (rem_s2 != '0);
	assign text_out.out_byte = data_s2[idx_s2];
	assign text_out.out_last = last_s2 && (rem_s2 == LenW'(1));
	// free when empty or once the last byte of the current burst leaves this cycle
	assign free = (rem_s2 == '0) || ((rem_s2 == LenW'(1)) && text_out.ready);

	always_ff @(posedge clk) begin
		if (load) begin
			data_s2 <= burst_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_s2  <= '0;
			idx_s2  <= '0;
			last_s2 <= 1'b0;
		end else if (load) begin
			rem_s2  <= burst_ctl.count;
			idx_s2  <= '0;
			last_s2 <= burst_ctl.last;
		end else if (fire) begin
			rem_s2 <= rem_s2 - LenW'(1);
			idx_s2 <= idx_s2 + IdxW'(1);
		end
	end

endmodule

@@ hw/rtl/stream_substring_replace_unit.sv @@
// ----------------------------------------------------------------------------
// stream_substring_replace_unit
// Streaming find-and-replace over a byte stream with a last-byte flag.
// ----------------------------------------------------------------------------
// Takes one text byte per item and rewrites the stream so that every leftmost,
// non-overlapping occurrence of the search pattern (1 to MAX_PATTERN_BYTES
// bytes) becomes the replacement text (1 to MAX_REPLACEMENT_BYTES bytes).
// Bytes that might still start a match wait in a small window; the item that
// marks the last byte flushes it, and out_last rides on the final output byte.
// A zero pattern or replacement length makes the unit a plain pass-through.
// Timing: an input item is registered; once the result register is free, the
// compare logic loads the item's output burst into it, and the first output
// byte is offered from there. Each item yields 0 to 8 bytes; the result
// register plays them out one per cycle unless the output stalls, so an item
// producing more than one byte holds the input until its last byte leaves,
// and items producing zero or one byte stream at one item per cycle while the
// output is ready. The input register accepts a new item while a result still
// waits on the output side. Config registers are written through cfg, always
// ready, and must only change while the unit is idle.
// ----------------------------------------------------------------------------
module stream_substring_replace_unit #(
	parameter int MAX_PATTERN_BYTES     = 8,
	parameter int MAX_REPLACEMENT_BYTES = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	ssr_text_if.sink   text_in,
	ssr_out_if.source  text_out,
	ssr_cfg_if.sink    cfg
);

	localparam int BurstDepth = (MAX_PATTERN_BYTES > MAX_REPLACEMENT_BYTES) ?
	                            MAX_PATTERN_BYTES : MAX_REPLACEMENT_BYTES;
	localparam int LenW = ssr_pkg::LEN_W;
	localparam int PatW = MAX_PATTERN_BYTES * ssr_pkg::BYTE_W;
	localparam int RepW = MAX_REPLACEMENT_BYTES * ssr_pkg::BYTE_W;

	// config registers; only the bytes the parameters allow are kept
	logic [PatW-1:0] pattern_q;
	logic [LenW-1:0] plen_q;
	logic [RepW-1:0] repl_q;
	logic [LenW-1:0] rlen_q;
	logic [LenW-1:0] plen;
	logic [LenW-1:0] rlen;

	// input stage
	logic                       valid_s1;
	logic [ssr_pkg::BYTE_W-1:0] byte_s1;
	logic                       last_s1;

	logic                       in_fire;
	logic                       xfer;
	logic                       burst_free;
	logic [ssr_pkg::BYTE_W-1:0] burst_bytes [BurstDepth];
	ssr_pkg::burst_ctl_t        burst_ctl;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			plen_q    <= '0;
			repl_q    <= '0;
			rlen_q    <= '0;
		end else if (cfg.valid) begin
			case (ssr_pkg::cfg_reg_t'(cfg.index))
				ssr_pkg::CFG_SEARCH_PATTERN:     pattern_q <= cfg.data[PatW-1:0];
				ssr_pkg::CFG_PATTERN_LENGTH:     plen_q    <= cfg.data[LenW-1:0];
				ssr_pkg::CFG_REPLACEMENT_TEXT:   repl_q    <= cfg.data[RepW-1:0];
				ssr_pkg::CFG_REPLACEMENT_LENGTH: rlen_q    <= cfg.data[LenW-1:0];
				default: begin
				end
			endcase
		end
	end

	// lengths above the supported maxima saturate
	assign plen = (plen_q > LenW'(MAX_PATTERN_BYTES)) ? LenW'(MAX_PATTERN_BYTES) : plen_q;
	assign rlen = (rlen_q > LenW'(MAX_REPLACEMENT_BYTES)) ?
	              LenW'(MAX_REPLACEMENT_BYTES) : rlen_q;

	// the held item moves on (and updates the window) once the burst stage frees
	assign xfer          = valid_s1 && burst_free;
	assign text_in.ready = !valid_s1 || xfer;
	assign in_fire       = text_in.valid && text_in.ready;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= text_in.text_byte;
			last_s1 <= text_in.text_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (xfer) begin
			valid_s1 <= 1'b0;
		end
	end

	ssr_window #(
		.MAX_PATTERN_BYTES     (MAX_PATTERN_BYTES),
		.MAX_REPLACEMENT_BYTES (MAX_REPLACEMENT_BYTES),
		.BURST_DEPTH           (BurstDepth)
	) u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.commit      (xfer),
		.text_byte   (byte_s1),
		.text_last   (last_s1),
		.pattern     (pattern_q),
		.plen        (plen),
		.repl        (repl_q),
		.rlen        (rlen),
		.burst_bytes (burst_bytes),
		.burst_ctl   (burst_ctl)
	);

	ssr_burst #(
		.BURST_DEPTH (BurstDepth)
	) u_burst (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (xfer),
		.burst_bytes (burst_bytes),
		.burst_ctl   (burst_ctl),
		.free        (burst_free),
		.text_out    (text_out)
	);

endmodule

@@ hw/rtl/ssr_checker.sv @@
// ----------------------------------------------------------------------------
// ssr_checker
// Port-level checks for the stream substring replace unit, bound to the top.
// ----------------------------------------------------------------------------
`include "stream_substring_replace_unit_macros.svh"

module ssr_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [ssr_pkg::BYTE_W-1:0] out_byte,
	input logic                       out_last
);

	// a stalled output item stays offered
	`SSR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// a stalled output item keeps its payload
	`SSR_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_byte) && $stable(out_last))

	// with nothing in the result register the input side is never blocked
	`SSR_ASSERT_IMPLIES(a_idle_ready, clk, arst_n, !out_valid, in_ready)

	// an item taken while the output then stalls fills the input register
	`SSR_ASSERT_IMPLIES(a_stall_full, clk, arst_n, (in_valid && in_ready) ##1 (out_valid && !out_ready), !in_ready)

endmodule

bind stream_substring_replace_unit ssr_checker u_ssr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (text_in.valid),
	.in_ready  (text_in.ready),
	.out_valid (text_out.valid),
	.out_ready (text_out.ready),
	.out_byte  (text_out.out_byte),
	.out_last  (text_out.out_last)
);

@@ sim/stream_substring_replace_unit_tb.sv @@
// ----------------------------------------------------------------------------
// stream_substring_replace_unit_tb
// Self-checking bench for the streaming find-and-replace unit.
// ----------------------------------------------------------------------------
// A directed part covers the special cases first:
//   - pass-through at reset
//   - a match on the last byte
//   - a partial match flushed at end of text
//   - length saturation
//   - a pattern shortened mid-text
//   - a pass-through switch that drops pending bytes
// Random phases follow. Each phase programs a new pattern and replacement and
// sends texts built mostly from pattern pieces. A scoreboard tracks the window
// and predicts every output item in order. Both sides idle at random, and the
// output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module stream_substring_replace_unit_tb;

	localparam int BYTE_W = ssr_pkg::BYTE_W;
	localparam int LEN_W = ssr_pkg::LEN_W;
	localparam int MAX_BYTES = 8;   // both pattern and replacement limits
	localparam int TEXT_ITEMS = 270;
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		logic [BYTE_W-1:0] b;
		logic              l;
	} text_item_t;

	// Tracks the window and queues the bytes that the unit must emit.
	class rewrite_scoreboard;
		logic [63:0]       pattern;
		logic [LEN_W-1:0]  pattern_len;
		logic [63:0]       replacement;
		logic [LEN_W-1:0]  replacement_len;
		logic [BYTE_W-1:0] window [MAX_BYTES];
		int                fill;
		int                emitted;
		int                errors;
		text_item_t        pending_text [$];

		function new();
			pattern = '0;
			pattern_len = '0;
			replacement = '0;
			replacement_len = '0;
			fill = 0;
			errors = 0;
		endfunction

		function void set_reg(ssr_pkg::cfg_reg_t idx, logic [63:0] d);
			case (idx)
				ssr_pkg::CFG_SEARCH_PATTERN:     pattern = d;
				ssr_pkg::CFG_PATTERN_LENGTH:     pattern_len = d[LEN_W-1:0];
				ssr_pkg::CFG_REPLACEMENT_TEXT:   replacement = d;
				ssr_pkg::CFG_REPLACEMENT_LENGTH: replacement_len = d[LEN_W-1:0];
				default: ;
			endcase
		endfunction

		function void emit(logic [BYTE_W-1:0] b);
			text_item_t it;
			it.b = b;
			it.l = 1'b0;
			pending_text.push_back(it);
			emitted++;
		endfunction

		function void emit_oldest();
			emit(window[0]);
			for (int i = 1; i < MAX_BYTES; i++)
				window[i-1] = window[i];
			fill--;
		endfunction

		// One accepted text item: update the window and queue its output bytes.
		function void note_text_byte(logic [BYTE_W-1:0] b, logic last);
			int plen;
			int rlen;
			bit hit;
			plen = (pattern_len > MAX_BYTES) ? MAX_BYTES : pattern_len;
			rlen = (replacement_len > MAX_BYTES) ? MAX_BYTES : replacement_len;
			emitted = 0;
			if (plen == 0 || rlen == 0) begin
				// pass-through; anything still in the window is dropped
				fill = 0;
				emit(b);
				pending_text[$].l = last;
				return;
			end
			window[fill] = b;
			fill++;
			hit = (fill == plen);
			if (hit) begin
				for (int i = 0; i < plen; i++)
					if (window[i] != pattern[8*i +: 8])
						hit = 0;
			end
			if (hit) begin
				for (int i = 0; i < rlen; i++)
					emit(replacement[8*i +: 8]);
				fill = 0;
			end else begin
				// without a hit the window drains to one short of the pattern
				while (fill >= plen)
					emit_oldest();
				if (last)
					while (fill > 0)
						emit_oldest();
			end
			if (last) begin
				fill = 0;
				if (emitted > 0)
					pending_text[$].l = 1'b1;
			end
		endfunction

		function void check_out_byte(logic [BYTE_W-1:0] b, logic l);
			text_item_t want;
			if (pending_text.size() == 0) begin
				errors++;
				$error("out item 0x%02h/%0b with nothing pending", b, l);
				return;
			end
			want = pending_text.pop_front();
			if (b !== want.b) begin
				errors++;
				$error("out_byte: expected 0x%02h, got 0x%02h", want.b, b);
			end
			if (l !== want.l) begin
				errors++;
				$error("out_last: expected %0b, got %0b", want.l, l);
			end
		endfunction

		function int outstanding();
			return pending_text.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ssr_text_if text_ch ();
	ssr_out_if  out_ch ();
	ssr_cfg_if  cfg_ch ();

	rewrite_scoreboard sb;

	// Run control shared by the driving processes.
	bit tx_idle;            // sender draws gaps
	bit rx_idle;            // receiver draws stalls
	int hold_off_cycles;    // one-shot long stall request for the receiver
	int sent;               // accepted text items

	// Current settings, used to shape the random text.
	logic [63:0]       cur_pattern;
	int                cur_plen;
	logic [BYTE_W-1:0] alpha [3];

	stream_substring_replace_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_in  (text_ch),
		.text_out (out_ch),
		.cfg      (cfg_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#1600000;
		$display("tb: failure");
		$finish;
	end

	// Output side: stall a random number of cycles per item, then take one.
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = rx_idle ? $urandom_range(0, 8) : 0;
			if (hold_off_cycles > 0) begin
				// long hold-off so the unit backs up into its input
				stall = hold_off_cycles;
				hold_off_cycles = 0;
			end
			if (stall > 0) begin
				out_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready = 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			sb.check_out_byte(out_ch.out_byte, out_ch.out_last);
			@(negedge clk);
		end
	end

	// Offer one text item after a random gap and wait for it to be taken.
	// valid stays high into the next item when no gap is drawn.
	task automatic send_char(input logic [BYTE_W-1:0] b, input logic last);
		int gap;
		gap = tx_idle ? $urandom_range(0, 8) : 0;
		@(negedge clk);
		if (gap > 0) begin
			text_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		text_ch.valid = 1'b1;
		text_ch.text_byte = b;
		text_ch.text_last = last;
		do @(posedge clk); while (!text_ch.ready);
		sb.note_text_byte(b, last);
		sent++;
	endtask

	// Stop offering, wait for every expected item, then let the unit settle
	// (items that emit nothing may still be in flight).
	task automatic wait_for_quiet();
		@(negedge clk);
		text_ch.valid = 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input ssr_pkg::cfg_reg_t idx, input logic [63:0] d);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = d;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_reg(idx, d);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Program all four registers; upper bits of the length words are junk.
	task automatic program_unit(input logic [63:0] pat, input int plen,
			input logic [63:0] repl, input int rlen);
		write_reg(ssr_pkg::CFG_SEARCH_PATTERN, pat);
		write_reg(ssr_pkg::CFG_PATTERN_LENGTH, {$urandom, $urandom} & 64'hffff_ffff_ffff_fff0
			| 64'(plen));
		write_reg(ssr_pkg::CFG_REPLACEMENT_TEXT, repl);
		write_reg(ssr_pkg::CFG_REPLACEMENT_LENGTH,
			{$urandom, $urandom} & 64'hffff_ffff_ffff_fff0 | 64'(rlen));
		cur_pattern = pat;
		cur_plen = plen;
	endtask

	// Random text built from pattern pieces, near-miss prefixes and filler.
	// Noisy texts skip the pattern pieces.
	task automatic send_text(input int n_chars, input bit noisy);
		logic [BYTE_W-1:0] txt [$];
		int pe;
		int pick;
		int cut;
		pe = (cur_plen > MAX_BYTES) ? MAX_BYTES : cur_plen;
		if (pe == 0)
			pe = 3;
		while (txt.size() < n_chars) begin
			pick = $urandom_range(0, 99);
			if (!noisy && pick < 35) begin
				for (int k = 0; k < pe; k++)
					txt.push_back(cur_pattern[8*k +: 8]);
			end else if (!noisy && pick < 55) begin
				cut = $urandom_range(1, pe);
				for (int k = 0; k < cut; k++)
					txt.push_back(cur_pattern[8*k +: 8]);
			end else if (pick < 80) begin
				txt.push_back(alpha[$urandom_range(0, 2)]);
			end else begin
				txt.push_back(BYTE_W'($urandom_range(0, 255)));
			end
		end
		while (txt.size() > n_chars)
			void'(txt.pop_back());
		foreach (txt[k])
			send_char(txt[k], k == n_chars - 1);
	endtask

	initial begin
		logic [63:0] pat;
		logic [63:0] repl;
		int plen;
		int rlen;
		int phase;
		int mark;

		sb = new();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		hold_off_cycles = 0;
		sent = 0;
		cur_pattern = '0;
		cur_plen = 0;
		text_ch.valid = 1'b0;
		text_ch.text_byte = '0;
		text_ch.text_last = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = ssr_pkg::CFG_SEARCH_PATTERN;
		cfg_ch.data = '0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// ---- directed ----

		// Reset leaves both lengths zero: plain pass-through.
		send_char(8'h00, 1'b0);
		send_char(8'hff, 1'b1);
		wait_for_quiet();

		// "ab" -> eight bytes; the final match lands on the last item.
		program_unit(64'h0000_0000_0000_6261, 2, 64'h00ff_5a11_7e80_01ff, 8);
		send_char(8'h78, 1'b0);
		send_char(8'h61, 1'b0);
		send_char(8'h62, 1'b0);
		send_char(8'h61, 1'b0);
		send_char(8'h62, 1'b1);
		// partial match still pending at end of text gets flushed
		send_char(8'h61, 1'b0);
		send_char(8'h61, 1'b1);
		wait_for_quiet();

		// Oversized lengths saturate to eight bytes.
		program_unit(64'hff00_ff00_00ff_00ff, 12, 64'h0123_4567_89ab_cdef, 15);
		for (int i = 0; i < MAX_BYTES; i++)
			send_char(cur_pattern[8*i +: 8], i == MAX_BYTES - 1);
		wait_for_quiet();

		// Pattern shortened while three bytes wait in the window.
		program_unit(64'h0000_0000_6463_6261, 4, 64'h0000_0000_0000_0021, 1);
		send_char(8'h61, 1'b0);
		send_char(8'h62, 1'b0);
		send_char(8'h63, 1'b0);
		wait_for_quiet();
		write_reg(ssr_pkg::CFG_PATTERN_LENGTH, 64'd2);
		send_char(8'h78, 1'b0);
		send_char(8'h78, 1'b1);
		wait_for_quiet();

		// Switching to pass-through drops a pending byte.
		send_char(8'h61, 1'b0);
		wait_for_quiet();
		write_reg(ssr_pkg::CFG_REPLACEMENT_LENGTH, 64'd0);
		send_char(8'h71, 1'b1);
		wait_for_quiet();

		// ---- random phases ----
		phase = 0;
		while (sent < TEXT_ITEMS) begin
			for (int i = 0; i < 3; i++)
				alpha[i] = BYTE_W'($urandom_range(0, 255));
			for (int i = 0; i < MAX_BYTES; i++)
				pat[8*i +: 8] = ($urandom_range(0, 99) < 85) ?
					alpha[$urandom_range(0, 2)] : BYTE_W'($urandom_range(0, 255));
			repl = {$urandom, $urandom};
			case (phase)
				0: begin plen = 8; rlen = 8; end
				1: begin plen = 1; rlen = 1; end
				default: begin
					plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) :
						$urandom_range(1, 8);
					rlen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) :
						$urandom_range(1, 8);
				end
			endcase
			program_unit(pat, plen, repl, rlen);

			// mix of no idling, one-sided and two-sided idling
			tx_idle = $urandom_range(0, 1);
			rx_idle = $urandom_range(0, 1);
			if (phase == 2) begin
				// long output stall while the input keeps streaming
				tx_idle = 1'b0;
				hold_off_cycles = 80;
			end

			mark = sent;
			while (sent - mark < 30 && sent < TEXT_ITEMS)
				send_text($urandom_range(1, 16), $urandom_range(0, 9) == 0);
			// every phase ends with the sender paused until all output is in
			wait_for_quiet();
			phase++;
		end

		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
